// ----- src/hhn_pkg.sv -----
// Package of the height histogram normaliser: field widths, codes and the
// command and status structures between the controller and the datapath.
// It depends on nothing.
package hhn_pkg;

   localparam int ACTION_W    = 2;
   localparam int SAMPLE_W    = 16;
   localparam int INDEX_W     = 7;
   localparam int COUNT_W     = 21;
   localparam int LEVEL_W     = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_RANGE_MIN = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RANGE_MAX = 1'd1;

   localparam logic [SAMPLE_W-1:0] RANGE_MIN_RESET = 16'h8000;
   localparam logic [SAMPLE_W-1:0] RANGE_MAX_RESET = 16'h7FFF;

   typedef struct packed {
      logic load;
      logic clr_start;
      logic clr_step;
      logic mul;
      logic div_start_bin;
      logic div_start_lvl;
      logic div_step;
      logic rd_bin;
      logic rd_idx;
      logic wr_inc;
      logic cnt_cap;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic div_done;
      logic bin_drop;
      logic largest_zero;
      logic out_full;
   } ctrl_status_type;

endpackage

// ----- src/hhn_req_if.sv -----
// Request channel of the height histogram normaliser.
// It depends on hhn_pkg for the field widths.
interface hhn_req_if;
   logic                                valid;
   logic                                ready;
   logic [hhn_pkg::ACTION_W-1:0]        action;
   logic signed [hhn_pkg::SAMPLE_W-1:0] height_sample;
   logic [hhn_pkg::INDEX_W-1:0]         bin_index;

   modport source (output valid, output action, output height_sample,
                   output bin_index, input ready);
   modport sink (input valid, input action, input height_sample,
                 input bin_index, output ready);
endinterface

// ----- src/hhn_rsp_if.sv -----
// Response channel of the height histogram normaliser.
// It depends on hhn_pkg for the field widths.
interface hhn_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [hhn_pkg::COUNT_W-1:0]  bin_count;
   logic [hhn_pkg::LEVEL_W-1:0]  bin_level;

   modport source (output valid, output bin_count, output bin_level, input ready);
   modport sink (input valid, input bin_count, input bin_level, output ready);
endinterface

// ----- src/hhn_csr_if.sv -----
// Register write channel of the height histogram normaliser.
// It depends on hhn_pkg for the index and data widths.
interface hhn_csr_if;
   logic                            valid;
   logic                            ready;
   logic [hhn_pkg::CSR_INDEX_W-1:0] index;
   logic [hhn_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/hhn_ram.sv -----
// Generic single write port, single read port RAM with a registered read.
// It depends on nothing.
module hhn_ram #(
   parameter int WIDTH = 21,
   parameter int DEPTH = 100
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/hhn_ctrl.sv -----
// Controller of the height histogram normaliser: sequences clearing, sample
// counting and bin reads. It depends on hhn_pkg for codes and command types.
module hhn_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [hhn_pkg::ACTION_W-1:0] req_action,
   output logic                         req_ready,
   input  hhn_pkg::ctrl_status_type     status,
   output hhn_pkg::ctrl_cmd_type        cmd
);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_MUL    = 4'd2;
   localparam logic [3:0] S_DSTART = 4'd3;
   localparam logic [3:0] S_DIVB   = 4'd4;
   localparam logic [3:0] S_BIN    = 4'd5;
   localparam logic [3:0] S_INC    = 4'd6;
   localparam logic [3:0] S_RDX    = 4'd7;
   localparam logic [3:0] S_CAP    = 4'd8;
   localparam logic [3:0] S_DIVL   = 4'd9;
   localparam logic [3:0] S_OUT    = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               case (req_action)
                  hhn_pkg::ACT_CLEAR: begin
                     cmd.clr_start = 1'b1;
                     state_in      = S_CLEAR;
                  end
                  hhn_pkg::ACT_ADD: begin
                     state_in = S_MUL;
                  end
                  hhn_pkg::ACT_READ: begin
                     state_in = S_RDX;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DSTART;
         end
         S_DSTART: begin
            cmd.div_start_bin = 1'b1;
            state_in          = S_DIVB;
         end
         S_DIVB: begin
            if (status.div_done) begin
               state_in = S_BIN;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_BIN: begin
            if (status.bin_drop) begin
               state_in = S_IDLE;
            end else begin
               cmd.rd_bin = 1'b1;
               state_in   = S_INC;
            end
         end
         S_INC: begin
            cmd.wr_inc = 1'b1;
            state_in   = S_IDLE;
         end
         S_RDX: begin
            cmd.rd_idx = 1'b1;
            state_in   = S_CAP;
         end
         S_CAP: begin
            cmd.cnt_cap = 1'b1;
            if (status.largest_zero) begin
               state_in = S_OUT;
            end else begin
               cmd.div_start_lvl = 1'b1;
               state_in          = S_DIVL;
            end
         end
         S_DIVL: begin
            if (status.div_done) begin
               state_in = S_OUT;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_OUT: begin
            if (!status.out_full) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/hhn_datapath.sv -----
// Datapath of the height histogram normaliser: range registers, bin store,
// bin multiplier, shared restoring divider and response register.
// It depends on hhn_pkg and on hhn_ram.
module hhn_datapath #(
   parameter int BINS        = 100,
   parameter int MAX_SAMPLES = 1048576
) (
   input  logic                                clock,
   input  logic                                reset,
   input  hhn_pkg::ctrl_cmd_type               cmd,
   output hhn_pkg::ctrl_status_type            status,
   input  logic signed [hhn_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [hhn_pkg::INDEX_W-1:0]         req_index,
   input  logic                                csr_we,
   input  logic [hhn_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [hhn_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [hhn_pkg::COUNT_W-1:0]         rsp_count,
   output logic [hhn_pkg::LEVEL_W-1:0]         rsp_level
);

   localparam int SW        = hhn_pkg::SAMPLE_W;
   localparam int CW        = hhn_pkg::COUNT_W;
   localparam int LW        = hhn_pkg::LEVEL_W;
   localparam int IDX_W     = $clog2(BINS);
   localparam int IW        = (IDX_W > hhn_pkg::INDEX_W) ? IDX_W : hhn_pkg::INDEX_W;
   localparam int BINS_W    = $clog2(BINS + 1) + 1;
   localparam int DIFF_W    = SW + 1;
   localparam int PROD_W    = DIFF_W + BINS_W;
   localparam int LVL_W     = CW + LW;
   localparam int DIV_W     = (PROD_W > LVL_W) ? PROD_W : LVL_W;
   localparam int DCNT_W    = $clog2(DIV_W + 1);
   localparam int CAP_LIMIT = (2 ** CW) - 1;
   localparam int COUNT_CAP = (MAX_SAMPLES < CAP_LIMIT) ? MAX_SAMPLES : CAP_LIMIT;

   localparam logic signed [BINS_W-1:0] BINS_S = BINS_W'(BINS);

   // Configuration registers.
   logic signed [SW-1:0] range_min_ff, range_min_in;
   logic signed [SW-1:0] range_max_ff, range_max_in;

   // Captured request.
   logic signed [SW-1:0] sample_ff, sample_in;
   logic [IDX_W-1:0]     idx_addr_ff, idx_addr_in;
   logic                 idx_ok_ff, idx_ok_in;

   // Bin computation.
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [DIFF_W-1:0] den_ff, den_in;
   logic                     neg_ff, neg_in;
   logic                     den_zero_ff, den_zero_in;
   logic [IDX_W-1:0]         bin_addr_ff, bin_addr_in;

   // Divider.
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [CW-1:0]     rem_ff, rem_in;
   logic [CW-1:0]     dvs_ff, dvs_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;

   // Histogram state and clearing sweep.
   logic [CW-1:0]    largest_ff, largest_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   // Response register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] rsp_count_ff, rsp_count_in;
   logic [LW-1:0] rsp_level_ff, rsp_level_in;

   logic                     ram_wr_en;
   logic [IDX_W-1:0]         ram_wr_addr;
   logic [CW-1:0]            ram_wr_data;
   logic                     ram_rd_en;
   logic [IDX_W-1:0]         ram_rd_addr;
   logic [CW-1:0]            ram_rd_data;

   logic signed [DIFF_W-1:0] diff;
   logic [PROD_W-1:0]        prod_mag;
   logic [DIFF_W-1:0]        den_mag;
   logic [CW:0]              rem_sh;
   logic                     rem_ge;
   logic [LVL_W-1:0]         lvl_dividend;
   logic                     quo_zero;
   logic                     quo_over;
   logic [IDX_W-1:0]         bin_sel;
   logic                     bin_drop;
   logic [CW-1:0]            inc_val;
   logic [CW-1:0]            cap_val;
   logic [IW-1:0]            idx_wide;
   logic [LW-1:0]            level_val;

   hhn_ram #(
      .WIDTH (CW),
      .DEPTH (BINS)
   ) u_bin_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      diff     = DIFF_W'(sample_ff) - DIFF_W'(range_min_ff);
      prod_mag = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
      den_mag  = den_ff[DIFF_W-1] ? DIFF_W'(-den_ff) : DIFF_W'(den_ff);

      rem_sh = {rem_ff, quo_ff[DIV_W-1]};
      rem_ge = rem_sh >= {1'b0, dvs_ff};

      quo_zero = quo_ff == '0;
      quo_over = quo_ff > DIV_W'(BINS - 1);
      if (den_zero_ff || quo_zero) begin
         bin_sel = '0;
      end else if (quo_over) begin
         bin_sel = IDX_W'(BINS - 1);
      end else begin
         bin_sel = quo_ff[IDX_W-1:0];
      end
      bin_drop = !den_zero_ff && !quo_zero && neg_ff;

      cap_val      = idx_ok_ff ? ram_rd_data : '0;
      lvl_dividend = {cap_val, LW'(0)} - LVL_W'(cap_val);
      inc_val      = (ram_rd_data < CW'(COUNT_CAP)) ? ram_rd_data + 1'b1 : ram_rd_data;
      idx_wide     = IW'(req_index);
      level_val    = (largest_ff == '0) ? '0 : quo_ff[LW-1:0];

      ram_wr_en   = cmd.clr_step || cmd.wr_inc;
      ram_wr_addr = cmd.clr_step ? clr_ff : bin_addr_ff;
      ram_wr_data = cmd.clr_step ? '0 : inc_val;
      ram_rd_en   = cmd.rd_bin || cmd.rd_idx;
      ram_rd_addr = cmd.rd_bin ? bin_sel : idx_addr_ff;
   end

   always_comb begin
      range_min_in = range_min_ff;
      range_max_in = range_max_ff;
      if (csr_we) begin
         case (csr_index)
            hhn_pkg::REG_RANGE_MIN: range_min_in = csr_data;
            hhn_pkg::REG_RANGE_MAX: range_max_in = csr_data;
            default: begin
               range_min_in = range_min_ff;
            end
         endcase
      end

      sample_in   = cmd.load ? req_sample : sample_ff;
      idx_addr_in = cmd.load ? idx_wide[IDX_W-1:0] : idx_addr_ff;
      idx_ok_in   = cmd.load ? (32'(req_index) < BINS) : idx_ok_ff;

      prod_in     = cmd.mul ? PROD_W'(diff) * PROD_W'(BINS_S) : prod_ff;
      den_in      = cmd.mul ? DIFF_W'(range_max_ff) - DIFF_W'(range_min_ff) : den_ff;
      neg_in      = cmd.div_start_bin ? (prod_ff[PROD_W-1] ^ den_ff[DIFF_W-1]) : neg_ff;
      den_zero_in = cmd.div_start_bin ? (den_ff == '0) : den_zero_ff;
      bin_addr_in = cmd.rd_bin ? bin_sel : bin_addr_ff;

      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      dcnt_in = dcnt_ff;
      if (cmd.div_start_bin) begin
         quo_in  = DIV_W'(prod_mag);
         rem_in  = '0;
         dvs_in  = CW'(den_mag);
         dcnt_in = DCNT_W'(DIV_W);
      end else if (cmd.div_start_lvl) begin
         quo_in  = DIV_W'(lvl_dividend);
         rem_in  = '0;
         dvs_in  = largest_ff;
         dcnt_in = DCNT_W'(DIV_W);
      end else if (cmd.div_step) begin
         quo_in  = {quo_ff[DIV_W-2:0], rem_ge};
         rem_in  = rem_ge ? CW'(rem_sh - {1'b0, dvs_ff}) : rem_sh[CW-1:0];
         dcnt_in = dcnt_ff - 1'b1;
      end

      largest_in = largest_ff;
      if (cmd.clr_start) begin
         largest_in = '0;
      end else if (cmd.wr_inc && (inc_val > largest_ff)) begin
         largest_in = inc_val;
      end

      clr_in = clr_ff;
      if (cmd.clr_start) begin
         clr_in = '0;
      end else if (cmd.clr_step) begin
         clr_in = clr_ff + 1'b1;
      end

      cnt_in = cmd.cnt_cap ? cap_val : cnt_ff;

      rsp_count_in = cmd.out_load ? cnt_ff : rsp_count_ff;
      rsp_level_in = cmd.out_load ? level_val : rsp_level_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_min_ff <= hhn_pkg::RANGE_MIN_RESET;
         range_max_ff <= hhn_pkg::RANGE_MAX_RESET;
         largest_ff   <= '0;
         clr_ff       <= '0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         range_min_ff <= range_min_in;
         range_max_ff <= range_max_in;
         largest_ff   <= largest_in;
         clr_ff       <= clr_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      idx_addr_ff  <= idx_addr_in;
      idx_ok_ff    <= idx_ok_in;
      prod_ff      <= prod_in;
      den_ff       <= den_in;
      neg_ff       <= neg_in;
      den_zero_ff  <= den_zero_in;
      bin_addr_ff  <= bin_addr_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      dvs_ff       <= dvs_in;
      cnt_ff       <= cnt_in;
      rsp_count_ff <= rsp_count_in;
      rsp_level_ff <= rsp_level_in;
   end

   assign status.clr_last     = clr_ff == IDX_W'(BINS - 1);
   assign status.div_done     = dcnt_ff == '0;
   assign status.bin_drop     = bin_drop;
   assign status.largest_zero = largest_ff == '0;
   assign status.out_full     = rsp_valid_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_count = rsp_count_ff;
   assign rsp_level = rsp_level_ff;

endmodule

// ----- src/height_histogram_normalizer.sv -----
// Height histogram normaliser. Each transaction on the request channel clears the
// histogram, counts one signed 16-bit height into one of BINS bins over the range
// held in range_min and range_max, or reads one bin back as its raw count and its
// level relative to the tallest bin, 65535 meaning equal to it. Only a read returns
// a response transaction. Items are handled one at a time: no request is taken
// until the last one is through. Adding a sample, and reading a bin while the
// histogram is not empty, both go through one shared restoring divider that
// settles one quotient bit per cycle over DIV_W bits, where DIV_W is the larger
// of 37 and the width of the bin product (37 at the default BINS). A read while
// the histogram is empty skips the divider. A clear writes one bin store entry per
// cycle, and the same sweep runs straight after reset before the first request
// is accepted. The response sits in an output register, so the next request is
// taken while it waits. Register writes are always accepted and should only be
// made while the block is idle.
module height_histogram_normalizer #(
   parameter int BINS        = 100,
   parameter int MAX_SAMPLES = 1048576
) (
   input logic       clock,
   input logic       reset,
   hhn_req_if.sink   req_ch,
   hhn_rsp_if.source rsp_ch,
   hhn_csr_if.sink   csr_ch
);

   hhn_pkg::ctrl_cmd_type    cmd;
   hhn_pkg::ctrl_status_type status;

   assign csr_ch.ready = 1'b1;

   hhn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_action (req_ch.action),
      .req_ready  (req_ch.ready),
      .status     (status),
      .cmd        (cmd)
   );

   hhn_datapath #(
      .BINS        (BINS),
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_sample (req_ch.height_sample),
      .req_index  (req_ch.bin_index),
      .csr_we     (csr_ch.valid),
      .csr_index  (csr_ch.index),
      .csr_data   (csr_ch.data),
      .rsp_ready  (rsp_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .rsp_count  (rsp_ch.bin_count),
      .rsp_level  (rsp_ch.bin_level)
   );

endmodule
